>>> sv/vcp_cap_pkg.sv
package vcp_cap_pkg;

  localparam int MAX_NEST = 255;
  localparam int DEPTH_W = $clog2(MAX_NEST + 1);

  // One character causes at most three results.
  localparam int MAX_RES = 3;
  localparam int RES_IDX_W = $clog2(MAX_RES);
  localparam int CNT_W = $clog2(MAX_RES + 1);

  typedef enum logic {
    KIND_ENTRY  = 1'b0,
    KIND_STATUS = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_NOT_FOUND = 2'd0,
    ST_CLOSED    = 2'd1,
    ST_UNCLOSED  = 2'd2,
    ST_NEST_OVF  = 2'd3
  } status_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  vcp_code;
    logic [15:0] feature_value;
    logic        has_value;
    logic        last_of_capability;
    logic [1:0]  section_status;
  } entry_t;

  typedef struct packed {
    logic [CNT_W-1:0]           count;
    entry_t [MAX_RES-1:0]       slot;
  } bundle_t;

endpackage

>>> sv/vcp_cap_if.sv
interface vcp_cap_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_string;

  modport source (output valid, output ch, output end_of_string, input ready);
  modport sink (input valid, input ch, input end_of_string, output ready);
endinterface

interface vcp_cap_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  vcp_code;
  logic [15:0] feature_value;
  logic        has_value;
  logic        last_of_capability;
  logic [1:0]  section_status;

  modport source (output valid, output kind, output vcp_code, output feature_value,
                  output has_value, output last_of_capability, output section_status,
                  input ready);
  modport sink (input valid, input kind, input vcp_code, input feature_value,
                input has_value, input last_of_capability, input section_status,
                output ready);
endinterface

>>> sv/vcp_cap_core.sv
module vcp_cap_core
  import vcp_cap_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] ch,
  input  logic       eos,
  output bundle_t    bundle
);

  typedef enum logic [1:0] {
    PH_SEARCH,
    PH_SECTION,
    PH_CLOSED
  } phase_t;

  typedef enum logic [2:0] {
    SS_EXPECT,
    SS_CODE,
    SS_AFTER,
    SS_BAD_AFTER,
    SS_BAD_SKIP,
    SS_LIST,
    SS_VALUE
  } sub_t;

  localparam logic [3:0][7:0] KEY_TEXT = {8'h28, 8'h70, 8'h63, 8'h76};
  localparam logic [7:0] CH_V = 8'h76;
  localparam logic [7:0] CH_OPEN = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;

  phase_t             phase_r, phase_nxt;
  logic [1:0]         match_r, match_nxt;
  logic [DEPTH_W-1:0] sect_depth_r, sect_depth_nxt;
  logic [DEPTH_W-1:0] skip_depth_r, skip_depth_nxt;
  logic [15:0]        tok_r, tok_nxt;
  logic               tok_ovf_r, tok_ovf_nxt;
  sub_t               sub_r, sub_nxt;
  logic [7:0]         pcode_r, pcode_nxt;
  logic [15:0]        pval_r, pval_nxt;
  logic               pvalid_r, pvalid_nxt;
  logic               nest_ovf_r, nest_ovf_nxt;

  logic               dig_ok;
  logic [3:0]         dig;
  logic               is_ws;
  logic               done;
  logic               closed;
  logic [CNT_W-1:0]   cnt;
  status_t            st;

  function automatic entry_t mk_entry(input logic kind, input logic [7:0] code,
                                      input logic [15:0] val, input logic has,
                                      input logic last, input logic [1:0] status);
    entry_t e;
    e.kind = kind;
    e.vcp_code = code;
    e.feature_value = val;
    e.has_value = has;
    e.last_of_capability = last;
    e.section_status = status;
    return e;
  endfunction

  always_comb begin
    dig_ok = 1'b1;
    dig = 4'd0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      dig = ch[3:0];
    end else if ((ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46)) begin
      dig = 4'(ch[2:0] + 3'd1) + 4'd8;
    end else begin
      dig_ok = 1'b0;
    end
    is_ws = (ch == 8'h20) || (ch >= 8'h09 && ch <= 8'h0D);
  end

  always_comb begin
    phase_nxt = phase_r;
    match_nxt = match_r;
    sect_depth_nxt = sect_depth_r;
    skip_depth_nxt = skip_depth_r;
    tok_nxt = tok_r;
    tok_ovf_nxt = tok_ovf_r;
    sub_nxt = sub_r;
    pcode_nxt = pcode_r;
    pval_nxt = pval_r;
    pvalid_nxt = pvalid_r;
    nest_ovf_nxt = nest_ovf_r;
    bundle = '0;
    cnt = '0;
    done = 1'b0;
    closed = 1'b0;
    st = ST_NOT_FOUND;

    if (accept) begin
      case (phase_r)
        PH_SEARCH: begin
          if (ch == KEY_TEXT[match_r]) begin
            if (match_r == 2'd3) begin
              phase_nxt = PH_SECTION;
              sect_depth_nxt = DEPTH_W'(1);
              sub_nxt = SS_EXPECT;
            end else begin
              match_nxt = match_r + 2'd1;
            end
          end else begin
            match_nxt = (ch == CH_V) ? 2'd1 : 2'd0;
          end
        end
        PH_SECTION: begin
          if (ch == CH_OPEN) begin
            if (sect_depth_r >= DEPTH_W'(MAX_NEST)) begin
              nest_ovf_nxt = 1'b1;
            end else begin
              sect_depth_nxt = sect_depth_r + DEPTH_W'(1);
            end
          end else if (ch == CH_CLOSE) begin
            if (sect_depth_r != '0) begin
              sect_depth_nxt = sect_depth_r - DEPTH_W'(1);
            end
            closed = (sect_depth_r <= DEPTH_W'(1));
          end

          if (closed) begin
            if (sub_r == SS_CODE && !tok_ovf_r && tok_r <= 16'h00FF) begin
              bundle.slot[cnt[RES_IDX_W-1:0]] =
                mk_entry(KIND_ENTRY, tok_r[7:0], 16'd0, 1'b0, 1'b1, ST_NOT_FOUND);
              cnt = cnt + CNT_W'(1);
            end else if (sub_r == SS_AFTER) begin
              bundle.slot[cnt[RES_IDX_W-1:0]] =
                mk_entry(KIND_ENTRY, pcode_r, 16'd0, 1'b0, 1'b1, ST_NOT_FOUND);
              cnt = cnt + CNT_W'(1);
            end
            phase_nxt = PH_CLOSED;
          end else begin
            // The states are visited in the order below, so a character that
            // ends one token falls through to the states that follow it.
            if (sub_nxt == SS_CODE) begin
              if (dig_ok) begin
                if (tok_nxt > 16'h0FFF) begin
                  tok_ovf_nxt = 1'b1;
                end else begin
                  tok_nxt = {tok_nxt[11:0], dig};
                end
                done = 1'b1;
              end else if (tok_ovf_nxt || tok_nxt > 16'h00FF) begin
                sub_nxt = SS_BAD_AFTER;
              end else begin
                pcode_nxt = tok_nxt[7:0];
                sub_nxt = SS_AFTER;
              end
            end

            if (!done && sub_nxt == SS_AFTER) begin
              if (is_ws) begin
                done = 1'b1;
              end else if (ch == CH_OPEN) begin
                pvalid_nxt = 1'b0;
                pval_nxt = 16'd0;
                sub_nxt = SS_LIST;
                done = 1'b1;
              end else begin
                bundle.slot[cnt[RES_IDX_W-1:0]] =
                  mk_entry(KIND_ENTRY, pcode_nxt, 16'd0, 1'b0, 1'b1, ST_NOT_FOUND);
                cnt = cnt + CNT_W'(1);
                sub_nxt = SS_EXPECT;
              end
            end else if (!done && sub_nxt == SS_BAD_AFTER) begin
              if (is_ws) begin
                done = 1'b1;
              end else if (ch == CH_OPEN) begin
                skip_depth_nxt = DEPTH_W'(1);
                sub_nxt = SS_BAD_SKIP;
                done = 1'b1;
              end else begin
                sub_nxt = SS_EXPECT;
              end
            end

            if (!done && sub_nxt == SS_VALUE) begin
              if (dig_ok) begin
                if (tok_nxt > 16'h0FFF) begin
                  tok_ovf_nxt = 1'b1;
                end else begin
                  tok_nxt = {tok_nxt[11:0], dig};
                end
                done = 1'b1;
              end else begin
                if (!tok_ovf_nxt) begin
                  if (pvalid_nxt) begin
                    bundle.slot[cnt[RES_IDX_W-1:0]] =
                      mk_entry(KIND_ENTRY, pcode_nxt, pval_nxt, 1'b1, 1'b0, ST_NOT_FOUND);
                    cnt = cnt + CNT_W'(1);
                  end
                  pval_nxt = tok_nxt;
                  pvalid_nxt = 1'b1;
                end
                sub_nxt = SS_LIST;
              end
            end

            if (!done) begin
              case (sub_nxt)
                SS_BAD_SKIP: begin
                  if (ch == CH_OPEN) begin
                    if (skip_depth_nxt >= DEPTH_W'(MAX_NEST)) begin
                      nest_ovf_nxt = 1'b1;
                    end else begin
                      skip_depth_nxt = skip_depth_nxt + DEPTH_W'(1);
                    end
                  end else if (ch == CH_CLOSE) begin
                    if (skip_depth_nxt != '0) begin
                      skip_depth_nxt = skip_depth_nxt - DEPTH_W'(1);
                    end
                    if (skip_depth_nxt == '0) begin
                      sub_nxt = SS_EXPECT;
                    end
                  end
                end
                SS_LIST: begin
                  if (ch == CH_CLOSE) begin
                    bundle.slot[cnt[RES_IDX_W-1:0]] =
                      mk_entry(KIND_ENTRY, pcode_nxt, pvalid_nxt ? pval_nxt : 16'd0,
                               pvalid_nxt, 1'b1, ST_NOT_FOUND);
                    cnt = cnt + CNT_W'(1);
                    pvalid_nxt = 1'b0;
                    pval_nxt = 16'd0;
                    sub_nxt = SS_EXPECT;
                  end else if (dig_ok) begin
                    tok_nxt = {12'd0, dig};
                    tok_ovf_nxt = 1'b0;
                    sub_nxt = SS_VALUE;
                  end
                end
                default: begin
                  sub_nxt = SS_EXPECT;
                  if (dig_ok) begin
                    tok_nxt = {12'd0, dig};
                    tok_ovf_nxt = 1'b0;
                    sub_nxt = SS_CODE;
                  end
                end
              endcase
            end
          end
        end
        default: begin
        end
      endcase

      if (eos) begin
        if (phase_nxt == PH_SEARCH) begin
          st = ST_NOT_FOUND;
        end else if (nest_ovf_nxt) begin
          st = ST_NEST_OVF;
        end else if (phase_nxt == PH_CLOSED) begin
          st = ST_CLOSED;
        end else begin
          st = ST_UNCLOSED;
        end
        bundle.slot[cnt[RES_IDX_W-1:0]] =
          mk_entry(KIND_STATUS, 8'd0, 16'd0, 1'b0, 1'b0, st);
        cnt = cnt + CNT_W'(1);

        phase_nxt = PH_SEARCH;
        match_nxt = 2'd0;
        sect_depth_nxt = '0;
        skip_depth_nxt = '0;
        tok_nxt = 16'd0;
        tok_ovf_nxt = 1'b0;
        sub_nxt = SS_EXPECT;
        pcode_nxt = 8'd0;
        pval_nxt = 16'd0;
        pvalid_nxt = 1'b0;
        nest_ovf_nxt = 1'b0;
      end
    end

    bundle.count = cnt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SEARCH;
      match_r <= 2'd0;
      sect_depth_r <= '0;
      skip_depth_r <= '0;
      tok_r <= 16'd0;
      tok_ovf_r <= 1'b0;
      sub_r <= SS_EXPECT;
      pcode_r <= 8'd0;
      pval_r <= 16'd0;
      pvalid_r <= 1'b0;
      nest_ovf_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      match_r <= match_nxt;
      sect_depth_r <= sect_depth_nxt;
      skip_depth_r <= skip_depth_nxt;
      tok_r <= tok_nxt;
      tok_ovf_r <= tok_ovf_nxt;
      sub_r <= sub_nxt;
      pcode_r <= pcode_nxt;
      pval_r <= pval_nxt;
      pvalid_r <= pvalid_nxt;
      nest_ovf_r <= nest_ovf_nxt;
    end
  end

  a_eos_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    accept && eos |=> phase_r == PH_SEARCH && sub_r == SS_EXPECT && !nest_ovf_r)
    else $error("parser state not cleared after end of string");

  a_section_depth: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_SECTION |-> sect_depth_r != '0)
    else $error("open section with zero depth");

  a_closed_depth: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_CLOSED |-> sect_depth_r == '0)
    else $error("closed section with nonzero depth");

endmodule

>>> sv/vcp_cap_outq.sv
module vcp_cap_outq
  import vcp_cap_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  bundle_t        bundle,
  output logic           ready,
  vcp_cap_out_if.source  out_chan
);

  logic [CNT_W-1:0]     rem_r;
  logic [RES_IDX_W-1:0] head_r;
  entry_t [MAX_RES-1:0] slot_r;
  entry_t               cur;
  logic                 out_fire;

  assign cur = slot_r[head_r];
  assign out_fire = out_chan.valid && out_chan.ready;

  // A new request may enter once the last buffered result leaves.
  assign ready = (rem_r == '0) || (rem_r == CNT_W'(1) && out_chan.ready);

  assign out_chan.valid = (rem_r != '0);
  assign out_chan.kind = cur.kind;
  assign out_chan.vcp_code = cur.vcp_code;
  assign out_chan.feature_value = cur.feature_value;
  assign out_chan.has_value = cur.has_value;
  assign out_chan.last_of_capability = cur.last_of_capability;
  assign out_chan.section_status = cur.section_status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
      head_r <= '0;
    end else if (load) begin
      rem_r <= bundle.count;
      head_r <= '0;
    end else if (out_fire) begin
      rem_r <= rem_r - CNT_W'(1);
      head_r <= head_r + RES_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot_r <= bundle.slot;
    end
  end

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    load && bundle.count != '0 |=> out_chan.valid)
    else $error("loaded results not presented");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && cur.kind == KIND_STATUS |-> rem_r == CNT_W'(1))
    else $error("status item is not the last result of its request");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r != '0 |-> ({1'b0, head_r} + {1'b0, rem_r}) <= 3'(MAX_RES))
    else $error("result index beyond buffer");

endmodule

>>> sv/vcp_capability_list_parser.sv
// The first result of a request appears in the cycle after it is accepted.
// Throughput: one character per cycle while each character causes at most one
// result and the output is not stalled; a character that causes more results
// (up to three) holds the next character until the single output port drains them.
// Reset: synchronous, active low; clears the parser state and drops buffered results.
module vcp_capability_list_parser
  import vcp_cap_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  vcp_cap_in_if.sink    in_chan,
  vcp_cap_out_if.source out_chan
);

  logic    q_ready;
  logic    accept;
  bundle_t bundle;

  assign in_chan.ready = q_ready;
  assign accept = in_chan.valid && q_ready;

  vcp_cap_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .ch     (in_chan.ch),
    .eos    (in_chan.end_of_string),
    .bundle (bundle)
  );

  vcp_cap_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (accept),
    .bundle   (bundle),
    .ready    (q_ready),
    .out_chan (out_chan)
  );

endmodule

>>> tb/sv/vcp_cap_checker.sv
module vcp_cap_checker
  import vcp_cap_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  vcp_cap_in_if  in_mon,
  vcp_cap_out_if out_mon,
  output int     fail_count,
  output int     results_due
);

  typedef enum logic [1:0] {
    SCAN_SEARCH,
    SCAN_SECTION,
    SCAN_CLOSED
  } scan_t;

  typedef enum logic [2:0] {
    TOK_EXPECT,
    TOK_CODE,
    TOK_AFTER,
    TOK_BAD_AFTER,
    TOK_BAD_SKIP,
    TOK_LIST,
    TOK_VALUE
  } tok_t;

  localparam logic [7:0]  CH_OPEN  = 8'h28;
  localparam logic [7:0]  CH_CLOSE = 8'h29;
  localparam logic [7:0]  CH_V     = 8'h76;
  localparam logic [31:0] KEY_TEXT = {8'h76, 8'h63, 8'h70, 8'h28};

  scan_t              scan;
  logic [2:0]         match_len;
  logic [DEPTH_W-1:0] sec_depth;
  logic [DEPTH_W-1:0] skip_depth;
  logic [15:0]        tok_val;
  logic               tok_ovf;
  tok_t               tok_state;
  logic [7:0]         cap_code;
  logic [15:0]        held_val;
  logic               held_ok;
  logic               nest_ovf;
  entry_t             entries_due[$];

  function automatic logic [7:0] key_char(int i);
    return KEY_TEXT[31-8*i -: 8];
  endfunction

  function automatic bit is_space(logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic int hex_val(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
    return -1;
  endfunction

  task automatic clear_parser();
    scan       = SCAN_SEARCH;
    match_len  = '0;
    sec_depth  = '0;
    skip_depth = '0;
    tok_val    = '0;
    tok_ovf    = 1'b0;
    tok_state  = TOK_EXPECT;
    cap_code   = '0;
    held_val   = '0;
    held_ok    = 1'b0;
    nest_ovf   = 1'b0;
  endtask

  task automatic add_result(kind_t k, logic [7:0] code, logic [15:0] val, logic has,
                            logic last, status_t st);
    entry_t e;
    e.kind               = k;
    e.vcp_code           = code;
    e.feature_value      = val;
    e.has_value          = has;
    e.last_of_capability = last;
    e.section_status     = st;
    entries_due = {entries_due, e};
  endtask

  task automatic take_digit(int d);
    if (tok_val > 16'h0FFF) tok_ovf = 1'b1;
    else tok_val = {tok_val[11:0], 4'(d)};
  endtask

  task automatic feed_token(logic [7:0] c);
    int d;
    bit again;
    d = hex_val(c);
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      case (tok_state)
        TOK_CODE: begin
          if (d >= 0) begin
            take_digit(d);
          end else begin
            if (tok_ovf || tok_val > 16'h00FF) begin
              tok_state = TOK_BAD_AFTER;
            end else begin
              cap_code  = tok_val[7:0];
              tok_state = TOK_AFTER;
            end
            again = 1'b1;
          end
        end
        TOK_AFTER: begin
          if (c == CH_OPEN) begin
            held_ok   = 1'b0;
            held_val  = '0;
            tok_state = TOK_LIST;
          end else if (!is_space(c)) begin
            add_result(KIND_ENTRY, cap_code, 16'h0, 1'b0, 1'b1, ST_NOT_FOUND);
            tok_state = TOK_EXPECT;
            again = 1'b1;
          end
        end
        TOK_BAD_AFTER: begin
          if (c == CH_OPEN) begin
            skip_depth = 1;
            tok_state  = TOK_BAD_SKIP;
          end else if (!is_space(c)) begin
            tok_state = TOK_EXPECT;
            again = 1'b1;
          end
        end
        TOK_BAD_SKIP: begin
          if (c == CH_OPEN) begin
            if (skip_depth >= MAX_NEST) nest_ovf = 1'b1;
            else skip_depth++;
          end else if (c == CH_CLOSE) begin
            if (skip_depth > 0) skip_depth--;
            if (skip_depth == 0) tok_state = TOK_EXPECT;
          end
        end
        TOK_LIST: begin
          if (c == CH_CLOSE) begin
            if (held_ok) add_result(KIND_ENTRY, cap_code, held_val, 1'b1, 1'b1, ST_NOT_FOUND);
            else add_result(KIND_ENTRY, cap_code, 16'h0, 1'b0, 1'b1, ST_NOT_FOUND);
            held_ok   = 1'b0;
            held_val  = '0;
            tok_state = TOK_EXPECT;
          end else if (d >= 0) begin
            tok_val   = 16'(d);
            tok_ovf   = 1'b0;
            tok_state = TOK_VALUE;
          end
        end
        TOK_VALUE: begin
          if (d >= 0) begin
            take_digit(d);
          end else begin
            if (!tok_ovf) begin
              if (held_ok) add_result(KIND_ENTRY, cap_code, held_val, 1'b1, 1'b0, ST_NOT_FOUND);
              held_val = tok_val;
              held_ok  = 1'b1;
            end
            tok_state = TOK_LIST;
            again = 1'b1;
          end
        end
        default: begin
          tok_state = TOK_EXPECT;
          if (d >= 0) begin
            tok_val   = 16'(d);
            tok_ovf   = 1'b0;
            tok_state = TOK_CODE;
          end
        end
      endcase
    end
  endtask

  task automatic predict_char(logic [7:0] c, logic eos);
    status_t st;
    case (scan)
      SCAN_SEARCH: begin
        if (match_len < 4 && c == key_char(match_len)) begin
          match_len++;
          if (match_len == 4) begin
            scan      = SCAN_SECTION;
            sec_depth = 1;
            tok_state = TOK_EXPECT;
          end
        end else begin
          match_len = (c == CH_V) ? 3'd1 : 3'd0;
        end
      end
      SCAN_SECTION: begin
        if (c == CH_OPEN) begin
          if (sec_depth >= MAX_NEST) nest_ovf = 1'b1;
          else sec_depth++;
          feed_token(c);
        end else if (c == CH_CLOSE && sec_depth <= 1) begin
          sec_depth = '0;
          // A code still being read or waiting for its list is flushed by the close.
          if (tok_state == TOK_CODE && !tok_ovf && tok_val <= 16'h00FF) begin
            add_result(KIND_ENTRY, tok_val[7:0], 16'h0, 1'b0, 1'b1, ST_NOT_FOUND);
          end else if (tok_state == TOK_AFTER) begin
            add_result(KIND_ENTRY, cap_code, 16'h0, 1'b0, 1'b1, ST_NOT_FOUND);
          end
          scan = SCAN_CLOSED;
        end else begin
          if (c == CH_CLOSE) sec_depth--;
          feed_token(c);
        end
      end
      default: begin
      end
    endcase
    if (eos) begin
      if (scan == SCAN_SEARCH) st = ST_NOT_FOUND;
      else if (nest_ovf) st = ST_NEST_OVF;
      else if (scan == SCAN_CLOSED) st = ST_CLOSED;
      else st = ST_UNCLOSED;
      add_result(KIND_STATUS, 8'h0, 16'h0, 1'b0, 1'b0, st);
      clear_parser();
    end
  endtask

  always @(posedge clk) begin
    entry_t want;
    if (!rst_n) begin
      clear_parser();
      entries_due.delete();
      fail_count = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (entries_due.size() == 0) begin
          fail_count++;
          $display("%0t: result with nothing expected, actual kind=%0d code=%h value=%h",
                   $time, out_mon.kind, out_mon.vcp_code, out_mon.feature_value,
                   " has=%0d last=%0d status=%0d", out_mon.has_value,
                   out_mon.last_of_capability, out_mon.section_status);
        end else begin
          want = entries_due.pop_front();
          if (want.kind !== out_mon.kind || want.vcp_code !== out_mon.vcp_code ||
              want.feature_value !== out_mon.feature_value ||
              want.has_value !== out_mon.has_value ||
              want.last_of_capability !== out_mon.last_of_capability ||
              want.section_status !== out_mon.section_status) begin
            fail_count++;
            $display("%0t: mismatch, expected kind=%0d code=%h value=%h has=%0d last=%0d",
                     $time, want.kind, want.vcp_code, want.feature_value, want.has_value,
                     want.last_of_capability, " status=%0d", want.section_status);
            $display("%0t:           actual kind=%0d code=%h value=%h has=%0d last=%0d",
                     $time, out_mon.kind, out_mon.vcp_code, out_mon.feature_value,
                     out_mon.has_value, out_mon.last_of_capability,
                     " status=%0d", out_mon.section_status);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) predict_char(in_mon.ch, in_mon.end_of_string);
    end
    results_due = entries_due.size();
  end

endmodule

>>> tb/sv/testbench.sv
module testbench;
  import vcp_cap_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_CHARS = 110;
  localparam int QUIET_TAIL   = 30;

  logic       clk;
  logic       rst_n;
  int         fail_count;
  int         results_due;
  int         cycle_count = 0;
  int         chars_sent;
  int         send_idle_pct;
  int         recv_stall_pct;
  logic [7:0] text_q[$];

  vcp_cap_in_if  in_chan();
  vcp_cap_out_if out_chan();

  vcp_capability_list_parser dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  vcp_cap_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_chan),
    .out_mon     (out_chan),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (recv_stall_pct > 0 && $urandom_range(1, 100) <= recv_stall_pct) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end
      out_chan.ready <= 1'b1;
    end
  end

  task automatic put_char(logic [7:0] c, logic eos);
    if (send_idle_pct > 0 && $urandom_range(1, 100) <= send_idle_pct) begin
      @(negedge clk);
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    in_chan.valid         <= 1'b1;
    in_chan.ch            <= c;
    in_chan.end_of_string <= eos;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_text();
    foreach (text_q[i]) put_char(text_q[i], i == text_q.size() - 1);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
  endtask

  task automatic add_byte(logic [7:0] c);
    text_q = {text_q, c};
  endtask

  task automatic push_str(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic send_literal(string s);
    text_q.delete();
    push_str(s);
    send_text();
  endtask

  task automatic push_hex(int ndig);
    int nib;
    repeat (ndig) begin
      nib = $urandom_range(0, 15);
      if (nib < 10) add_byte(8'(8'h30 + nib));
      else if ($urandom_range(0, 1) == 1) add_byte(8'(8'h41 + nib - 10));
      else add_byte(8'(8'h61 + nib - 10));
    end
  endtask

  task automatic push_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) add_byte(8'($urandom_range(0, 255)));
    else if (r < 6) add_byte(8'(8'h09 + r - 1));
    else if (r < 15) add_byte(8'h20);
  endtask

  task automatic build_noise_string();
    text_q.delete();
    repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic build_caps_string();
    text_q.delete();
    case ($urandom_range(0, 5))
      0: push_str("v");
      1: push_str("vc");
      2: push_str("vcp ");
      3: push_str("prot(x)");
      default: begin
      end
    endcase
    push_str("vcp(");
    repeat ($urandom_range(1, 4)) begin
      push_gap();
      case ($urandom_range(0, 9))
        0: push_hex(3);
        1: push_hex(5);
        default: push_hex($urandom_range(1, 2));
      endcase
      push_gap();
      case ($urandom_range(0, 3))
        0: begin
        end
        1: push_str(",");
        default: begin
          push_str("(");
          repeat ($urandom_range(0, 4)) begin
            push_hex(($urandom_range(0, 9) == 0) ? 5 : $urandom_range(1, 4));
            case ($urandom_range(0, 7))
              0: push_str("(1)");
              1: push_str(",");
              default: push_str(" ");
            endcase
          end
          push_str(")");
        end
      endcase
    end
    push_gap();
    if ($urandom_range(0, 7) != 0) push_str(")");
    if ($urandom_range(0, 3) == 0) push_str(" tail(2.2)");
  endtask

  initial begin
    int first_random;
    int strings_done;
    rst_n                 = 1'b0;
    in_chan.valid         = 1'b0;
    in_chan.ch            = 8'h0;
    in_chan.end_of_string = 1'b0;
    send_idle_pct         = 0;
    recv_stall_pct        = 0;
    chars_sent            = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct  = 10;
    recv_stall_pct = 10;
    send_literal("xyz");
    send_literal("v");
    send_literal("vcp(");
    send_literal("vvcp(00 FF(0 ffff 1)ab)");
    send_literal("vcp(12(34 12345 5) 100(3(4)) 1F");
    send_literal("vcp(123456(1) A0 ()b)");
    send_literal("vcp(c0 )xx(");
    send_literal("vcp(5 (6,7)0D\t(1A))");
    text_q.delete();
    push_str("vcp(");
    add_byte(8'h00);
    push_str("7");
    add_byte(8'hFF);
    push_str(")");
    send_text();
    wait_drained();

    first_random = chars_sent;
    strings_done = 0;
    while (chars_sent - first_random < RANDOM_CHARS) begin
      if (chars_sent - first_random > RANDOM_CHARS - QUIET_TAIL) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end else begin
        send_idle_pct  = 15 * $urandom_range(0, 2);
        recv_stall_pct = 15 * $urandom_range(0, 2);
      end
      if ($urandom_range(0, 7) == 0) build_noise_string();
      else build_caps_string();
      send_text();
      strings_done++;
      if (strings_done == 4) wait_drained();
    end
    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
